FILE: rtl/core/spdc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the sync packet deframer.
`default_nettype none
package spdc_pkg;

	localparam int unsigned MAX_PAYLOAD = 1023;
	localparam int unsigned LEN_W       = 10;
	localparam int unsigned CNT_W       = 10;

	localparam logic [7:0] SYNC_BYTE = 8'hFA;

	// parser phase codes
	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_GROUP   = 3'd1;
	localparam logic [2:0] PH_MASKS   = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CRC     = 3'd4;
	localparam logic [2:0] PH_VERDICT = 3'd5;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [CNT_W-1:0] LAST_MASK_IDX = CNT_W'(5);

	typedef struct packed {
		logic             kind;
		logic [CNT_W-1:0] offset;
		logic [7:0]       data_byte;
		logic [7:0]       group_select;
		logic [15:0]      mask_first;
		logic [15:0]      mask_second;
		logic [15:0]      mask_third;
		logic             crc_ok;
	} result_t;

	// CRC-16, polynomial 0x1021, byte at a time, no reflection
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = {crc_in[7:0], crc_in[15:8]};
		c = c ^ {8'h00, b};
		c = c ^ {12'h000, c[7:4]};
		c = c ^ {c[3:0], 12'h000};
		c = c ^ {3'b000, c[7:0], 5'b00000};
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sync_packet_deframer_crc16_top.sv
// Top level of the sync packet deframer: input register, parser and result register.
//
// Input channel: rx_byte with in_valid / in_stall; a word is taken at a clock edge
// with in_valid high and in_stall low. Output channel: one result word per payload
// byte (kind 0, offset, data_byte) and one verdict word per packet (kind 1,
// group_select, three masks, crc_ok), with out_valid / out_stall.
// Configuration: cfg_data carries payload_len, written when cfg_valid and cfg_ready
// are high; cfg_ready is always high. Write only while the block is idle.
// A taken input word is captured in the input register; the parser logic then writes
// its result into the result register; a receiver stall can hold it in between.
// Throughput: one word per cycle while the receiver does not stall; the CRC byte
// update and counter compare sit in a single stage between the two registers.
// When the receiver stalls, the result register holds and the input register fills;
// in_stall rises once both are full and falls as soon as the result is taken.
// Reset: asynchronous, active low; the parser returns to hunting for the sync byte,
// payload_len returns to 440 and both registers are emptied.
`default_nettype none
module sync_packet_deframer_crc16_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [7:0]                   rx_byte,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         kind,
	output logic [9:0]                   offset,
	output logic [7:0]                   data_byte,
	output logic [7:0]                   group_select,
	output logic [15:0]                  mask_first,
	output logic [15:0]                  mask_second,
	output logic [15:0]                  mask_third,
	output logic                         crc_ok,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [spdc_pkg::LEN_W-1:0]   cfg_data
);
	import spdc_pkg::*;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(440);

	logic [LEN_W-1:0] payload_len_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_q;
	result_t          res_q;
	logic             advance;
	logic             res_valid;
	result_t          res;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_len_q <= LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			payload_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	spdc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (valid_s1 && advance),
		.rx_byte     (byte_s1),
		.payload_len (payload_len_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	// hold the result while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign offset       = res_q.offset;
	assign data_byte    = res_q.data_byte;
	assign group_select = res_q.group_select;
	assign mask_first   = res_q.mask_first;
	assign mask_second  = res_q.mask_second;
	assign mask_third   = res_q.mask_third;
	assign crc_ok       = res_q.crc_ok;

endmodule
`default_nettype wire

FILE: rtl/core/spdc_parser.sv
// Framing state machine: hunt, header, payload, CRC and verdict generation.
`default_nettype none
module spdc_parser (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          step,
	input  wire  [7:0]                   rx_byte,
	input  wire  [spdc_pkg::LEN_W-1:0]   payload_len,
	output logic                         res_valid,
	output spdc_pkg::result_t            res
);
	import spdc_pkg::*;

	logic [2:0]       phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       group_q, group_d;
	logic [15:0]      mask_q [3];
	logic [15:0]      mask_d [3];
	logic [15:0]      rcrc_q, rcrc_d;

	logic [15:0]      crc_next;
	logic [1:0]       mask_idx;
	logic [LEN_W-1:0] eff_len;
	logic [CNT_W:0]   count_inc;

	assign crc_next  = crc16_byte(crc_q, rx_byte);
	assign mask_idx  = count_q[2:1];
	assign eff_len   = (payload_len == '0) ? LEN_W'(1) : payload_len;
	assign count_inc = {1'b0, count_q} + (CNT_W+1)'(1);

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		crc_d     = crc_q;
		group_d   = group_q;
		mask_d    = mask_q;
		rcrc_d    = rcrc_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_GROUP: begin
				crc_d   = crc_next;
				group_d = rx_byte;
				count_d = '0;
				phase_d = PH_MASKS;
			end
			PH_MASKS: begin
				crc_d = crc_next;
				if (!count_q[0]) begin
					mask_d[mask_idx] = {8'h00, rx_byte};
				end else begin
					mask_d[mask_idx] = {mask_q[mask_idx][7:0], rx_byte};
				end
				if (count_q >= LAST_MASK_IDX) begin
					count_d = '0;
					phase_d = PH_PAYLOAD;
				end else begin
					count_d = count_inc[CNT_W-1:0];
				end
			end
			PH_PAYLOAD: begin
				crc_d         = crc_next;
				res_valid     = 1'b1;
				res.kind      = KIND_PAYLOAD;
				res.offset    = count_q;
				res.data_byte = rx_byte;
				if (count_inc >= {1'b0, eff_len}) begin
					count_d = '0;
					phase_d = PH_CRC;
				end else begin
					count_d = count_inc[CNT_W-1:0];
				end
			end
			PH_CRC: begin
				crc_d = crc_next;
				if (count_q == '0) begin
					rcrc_d  = {8'h00, rx_byte};
					count_d = CNT_W'(1);
				end else begin
					rcrc_d  = {rcrc_q[7:0], rx_byte};
					count_d = '0;
					phase_d = PH_VERDICT;
				end
			end
			PH_VERDICT: begin
				// consume the trailing byte without looking at it
				res_valid        = 1'b1;
				res.kind         = KIND_VERDICT;
				res.group_select = group_q;
				res.mask_first   = mask_q[0];
				res.mask_second  = mask_q[1];
				res.mask_third   = mask_q[2];
				res.crc_ok       = (crc_q == 16'h0000);
				count_d          = '0;
				phase_d          = PH_HUNT;
			end
			default: begin
				count_d = '0;
				phase_d = PH_HUNT;
				if (rx_byte == SYNC_BYTE) begin
					crc_d   = 16'h0000;
					phase_d = PH_GROUP;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			crc_q   <= '0;
			group_q <= '0;
			mask_q  <= '{default: '0};
			rcrc_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			crc_q   <= crc_d;
			group_q <= group_d;
			mask_q  <= mask_d;
			rcrc_q  <= rcrc_d;
		end
	end

endmodule
`default_nettype wire

FILE: verif/tb_sync_packet_deframer_crc16_top.sv
// Testbench for the sync packet deframer: byte stimulus, parser prediction and result checks.
`timescale 1ns / 100ps

import spdc_pkg::*;

class packet_tracker;
	logic [LEN_W-1:0] len_cfg;
	logic [2:0]       ph;
	logic [CNT_W-1:0] idx;
	logic [15:0]      crc;
	logic [7:0]       grp;
	logic [15:0]      masks[3];
	logic [15:0]      rx_crc;
	result_t          expected_words[$];
	int               errors;
	int               verdicts_checked;

	function new();
		len_cfg = 10'd440;
		ph = PH_HUNT;
		idx = '0;
		crc = '0;
		grp = '0;
		foreach (masks[i]) masks[i] = '0;
		rx_crc = '0;
		errors = 0;
		verdicts_checked = 0;
	endfunction

	// bit-serial CRC-16, polynomial 0x1021, MSB first
	static function logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in;
		for (int i = 7; i >= 0; i--) begin
			if (c[15] ^ b[i])
				c = (c << 1) ^ 16'h1021;
			else
				c = c << 1;
		end
		return c;
	endfunction

	function void set_len(input logic [LEN_W-1:0] v);
		len_cfg = v;
	endfunction

	function int pending();
		return expected_words.size();
	endfunction

	function void note_byte(input logic [7:0] b);
		result_t r;
		int      m;
		int      eff;
		r = '0;
		case (ph)
			PH_GROUP: begin
				crc = crc_step(crc, b);
				grp = b;
				idx = '0;
				ph = PH_MASKS;
			end
			PH_MASKS: begin
				m = int'(idx >> 1) % 3;
				crc = crc_step(crc, b);
				if (!idx[0])
					masks[m] = {8'h00, b};
				else
					masks[m] = {masks[m][7:0], b};
				if (idx >= LAST_MASK_IDX) begin
					idx = '0;
					ph = PH_PAYLOAD;
				end else begin
					idx++;
				end
			end
			PH_PAYLOAD: begin
				crc = crc_step(crc, b);
				r.kind = KIND_PAYLOAD;
				r.offset = idx;
				r.data_byte = b;
				expected_words.push_back(r);
				eff = (len_cfg == 0) ? 1 : int'(len_cfg);
				if (eff > int'(MAX_PAYLOAD))
					eff = int'(MAX_PAYLOAD);
				if (int'(idx) + 1 >= eff) begin
					idx = '0;
					ph = PH_CRC;
				end else begin
					idx++;
				end
			end
			PH_CRC: begin
				crc = crc_step(crc, b);
				if (idx == 0) begin
					rx_crc = {8'h00, b};
					idx = CNT_W'(1);
				end else begin
					rx_crc = {rx_crc[7:0], b};
					idx = '0;
					ph = PH_VERDICT;
				end
			end
			PH_VERDICT: begin
				// byte after the CRC: content unused, even a sync byte
				r.kind = KIND_VERDICT;
				r.group_select = grp;
				r.mask_first = masks[0];
				r.mask_second = masks[1];
				r.mask_third = masks[2];
				r.crc_ok = (crc == 16'h0000);
				expected_words.push_back(r);
				idx = '0;
				ph = PH_HUNT;
			end
			default: begin
				idx = '0;
				ph = PH_HUNT;
				if (b == SYNC_BYTE) begin
					crc = '0;
					ph = PH_GROUP;
				end
			end
		endcase
	endfunction

	function void cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(input result_t got);
		result_t want;
		if (expected_words.size() == 0) begin
			$error("result word with nothing expected: kind %0b offset %0d", got.kind, got.offset);
			errors++;
			return;
		end
		want = expected_words.pop_front();
		cmp_field("kind", 16'(want.kind), 16'(got.kind));
		cmp_field("offset", 16'(want.offset), 16'(got.offset));
		cmp_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
		cmp_field("group_select", 16'(want.group_select), 16'(got.group_select));
		cmp_field("mask_first", want.mask_first, got.mask_first);
		cmp_field("mask_second", want.mask_second, got.mask_second);
		cmp_field("mask_third", want.mask_third, got.mask_third);
		cmp_field("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
		if (want.kind == KIND_VERDICT)
			verdicts_checked++;
	endfunction

	function void check_leftover();
		if (expected_words.size() != 0) begin
			$error("%0d result words still expected at end of run", expected_words.size());
			errors++;
		end
	endfunction
endclass

module tb_sync_packet_deframer_crc16_top;

	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef enum {FILL_RANDOM, FILL_SYNC, FILL_ONES} fill_e;
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       rx_byte;
	logic             out_valid;
	logic             out_stall;
	logic             kind;
	logic [9:0]       offset;
	logic [7:0]       data_byte;
	logic [7:0]       group_select;
	logic [15:0]      mask_first;
	logic [15:0]      mask_second;
	logic [15:0]      mask_third;
	logic             crc_ok;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data;

	packet_tracker sb = new();

	logic [7:0]  stim_q[$];
	int          pkt_items;
	int          burst_left;
	int unsigned cycle_cnt;
	stall_mode_e stall_mode;
	int          mode_left;
	logic [2:0]  pat_cnt;

	sync_packet_deframer_crc16_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.offset       (offset),
		.data_byte    (data_byte),
		.group_select (group_select),
		.mask_first   (mask_first),
		.mask_second  (mask_second),
		.mask_third   (mask_third),
		.crc_ok       (crc_ok),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", cycle_cnt);
		$display("** sync_packet_deframer_crc16_top: FAILED **");
		$finish;
	end

	// receiver stall pattern in one of four modes, picked anew at random when the current mode runs out
	initial begin
		stall_mode = STALL_NONE;
		mode_left = 0;
		pat_cnt = '0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				stall_mode = stall_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(32, 256);
			end
			mode_left--;
			pat_cnt++;
			case (stall_mode)
				STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
				STALL_PERIODIC: out_stall <= (pat_cnt < 3'd3);
				default:        out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({kind, offset, data_byte, group_select,
				mask_first, mask_second, mask_third, crc_ok});
	end

	function automatic void push_noise(input int n);
		for (int i = 0; i < n; i++)
			stim_q.push_back(8'($urandom));
	endfunction

	// sync, group, masks, payload, CRC and the trailing byte; cut >= 0 truncates
	function automatic void push_packet(input int n, input logic bad_crc, input fill_e fill,
			input int cut);
		logic [7:0]  body[$];
		logic [15:0] crc;
		logic [7:0]  b;
		crc = '0;
		body.push_back(SYNC_BYTE);
		for (int i = 0; i < 7 + n; i++) begin
			case (fill)
				FILL_SYNC: b = SYNC_BYTE;
				FILL_ONES: b = 8'hFF;
				default:   b = 8'($urandom);
			endcase
			body.push_back(b);
			crc = sb.crc_step(crc, b);
		end
		if (bad_crc)
			crc ^= 16'($urandom_range(1, 16'hFFFF));
		body.push_back(crc[15:8]);
		body.push_back(crc[7:0]);
		case (fill)
			FILL_SYNC: body.push_back(SYNC_BYTE);
			FILL_ONES: body.push_back(8'h00);
			default:   body.push_back(8'($urandom));
		endcase
		for (int i = 0; i < body.size() && (cut < 0 || i < cut); i++) begin
			stim_q.push_back(body[i]);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if ($urandom_range(0, 7) == 0) begin
				// long stretch without gaps
				burst_left = $urandom_range(40, 120);
				gap = 0;
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
		pkt_items++;
		@(negedge clk);
	endtask

	task automatic send_queue();
		while (stim_q.size() > 0)
			send_byte(stim_q.pop_front());
		in_valid <= 1'b0;
	endtask

	// hold until every expected word has come, then let the pipeline settle
	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_len(input logic [LEN_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_len(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int len;
		int eff;
		int r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		burst_left = 0;
		pkt_items = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// one packet at the reset length
		push_packet(440, 1'b0, FILL_RANDOM, -1);
		send_queue();
		drain();

		// zero length acts as one; sync bytes inside the packet and after the CRC
		write_len(10'd0);
		push_packet(1, 1'b0, FILL_SYNC, -1);
		push_packet(1, 1'b1, FILL_ONES, -1);
		stim_q.push_back(8'h00);
		stim_q.push_back(8'h7F);
		send_queue();
		drain();

		while (pkt_items < 950) begin
			r = $urandom_range(0, 19);
			if (r < 13)
				len = $urandom_range(1, 8);
			else if (r < 17)
				len = $urandom_range(9, 40);
			else if (r == 17)
				len = 0;
			else if (r == 18)
				len = 1;
			else
				len = $urandom_range(41, 64);
			eff = (len == 0) ? 1 : len;
			write_len(LEN_W'(len));
			repeat ($urandom_range(2, 6)) begin
				if ($urandom_range(0, 3) == 0)
					push_noise($urandom_range(1, 5));
				r = $urandom_range(0, 9);
				if (r < 7)
					push_packet(eff, ($urandom_range(0, 2) == 0), FILL_RANDOM, -1);
				else if (r < 9)
					push_packet(eff, 1'b0, FILL_RANDOM, $urandom_range(0, 10 + eff));
				else
					push_noise($urandom_range(3, 12));
			end
			send_queue();
			drain();
		end

		repeat (20) @(posedge clk);
		sb.check_leftover();
		if (sb.errors == 0)
			$display("** sync_packet_deframer_crc16_top: PASSED **");
		else
			$display("** sync_packet_deframer_crc16_top: FAILED **");
		$finish;
	end

endmodule

FILE: sync_packet_deframer_crc16_top.f
rtl/core/spdc_pkg.sv
rtl/core/spdc_parser.sv
rtl/core/sync_packet_deframer_crc16_top.sv
verif/tb_sync_packet_deframer_crc16_top.sv
